// ===== design/access_hazard_tracker_core_macros.svh =====
// Assertion macros shared by the hazard tracker checker.
// No dependencies; included by files that assert.
`ifndef ACCESS_HAZARD_TRACKER_CORE_MACROS_SVH
`define ACCESS_HAZARD_TRACKER_CORE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define AHT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("aht check failed: same-cycle rule");

// next-cycle implication, disabled while in reset
`define AHT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("aht check failed: next-cycle rule");

`endif

// ===== design/aht_pkg.sv =====
// Types and constants of the access hazard tracker.
// No dependencies; used by every module of the block.
package aht_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int KEY_BITS      = 16;
    localparam int FIELD_KEY_W   = 16;
    // stored/compared key bits: the field never carries more than FIELD_KEY_W
    localparam int KEY_W         = (KEY_BITS < FIELD_KEY_W) ? KEY_BITS : FIELD_KEY_W;

    typedef enum logic [0:0] {
        CMD_ACCESS = 1'b0,
        CMD_CLEAR  = 1'b1
    } t_cmd;

    typedef struct packed {
        t_cmd                   cmd;
        logic [FIELD_KEY_W-1:0] buffer_key;
        logic                   reads;
        logic                   writes;
        logic                   batch_last;
    } t_in_word;

    typedef struct packed {
        logic                   barrier_needed;
        logic [FIELD_KEY_W-1:0] barrier_key;
        logic                   src_read;
        logic                   src_write;
        logic                   dst_read;
        logic                   dst_write;
        logic                   table_overflow;
        logic                   batch_end;
    } t_out_word;

endpackage

// ===== design/aht_table.sv =====
// Key table of the hazard tracker: parallel key match, free-slot pick,
// barrier decision and entry update. Depends on aht_pkg.
module aht_table (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  aht_pkg::t_in_word i_word,
    output aht_pkg::t_out_word o_result
);

    localparam int N = aht_pkg::TABLE_ENTRIES;

    logic [N-1:0]              r_valid;
    logic [aht_pkg::KEY_W-1:0] r_key [N];
    logic [N-1:0]              r_last_rd;
    logic [N-1:0]              r_last_wr;

    logic [aht_pkg::KEY_W-1:0]       key;
    logic [aht_pkg::FIELD_KEY_W-1:0] key_ext;
    logic [N-1:0] hit_vec;
    logic [N-1:0] free_vec;
    logic [N-1:0] free_oh;
    logic         is_clear;
    logic         is_access;
    logic         hit;
    logic         full;
    logic         old_rd;
    logic         old_wr;
    logic         barrier;
    logic         store_new;

    always_comb begin
        key      = i_word.buffer_key[aht_pkg::KEY_W-1:0];
        key_ext  = '0;
        key_ext[aht_pkg::KEY_W-1:0] = key;
        is_clear  = (i_word.cmd == aht_pkg::CMD_CLEAR);
        is_access = !is_clear && (i_word.reads || i_word.writes);
        for (int i = 0; i < N; i++) begin
            hit_vec[i] = r_valid[i] && (r_key[i] == key);
        end
        // valid keys are unique, so at most one bit of hit_vec is set
        hit      = |hit_vec;
        full     = &r_valid;
        free_vec = ~r_valid;
        free_oh  = free_vec & (~free_vec + {{(N-1){1'b0}}, 1'b1});
        old_rd   = |(hit_vec & r_last_rd);
        old_wr   = |(hit_vec & r_last_wr);
        barrier   = is_access && hit && (old_wr || i_word.writes);
        store_new = is_access && !hit;

        o_result                = '0;
        o_result.batch_end      = i_word.batch_last;
        o_result.table_overflow = store_new && full;
        if (barrier) begin
            o_result.barrier_needed = 1'b1;
            o_result.barrier_key    = key_ext;
            o_result.src_read       = old_rd;
            o_result.src_write      = old_wr;
            o_result.dst_read       = i_word.reads;
            o_result.dst_write      = i_word.writes;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_fire) begin
            if (is_clear) begin
                r_valid <= '0;
            end else if (store_new) begin
                r_valid <= r_valid | free_oh;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < N; i++) begin
            if (i_fire && store_new && free_oh[i]) begin
                r_key[i]     <= key;
                r_last_rd[i] <= i_word.reads;
                r_last_wr[i] <= i_word.writes;
            end else if (i_fire && barrier && hit_vec[i]) begin
                r_last_rd[i] <= i_word.reads;
                r_last_wr[i] <= i_word.writes;
            end
        end
    end

endmodule

// ===== design/access_hazard_tracker_core.sv =====
// Read/write hazard scoreboard: input register, table lookup, result register.
// Each accepted word passes the input register and the parallel key compare into the result register;
// one word per cycle sustained while the output is not stalled, set by the combinational compare in aht_table.
// Synchronous active-low reset empties the table and both stage valids.
// Depends on aht_pkg and aht_table.
module access_hazard_tracker_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  aht_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output aht_pkg::t_out_word o_out_word
);

    logic               r_in_valid;
    logic               n_in_valid;
    aht_pkg::t_in_word  r_in_word;
    logic               r_out_valid;
    logic               n_out_valid;
    aht_pkg::t_out_word r_out_word;
    aht_pkg::t_out_word result;

    logic advance;
    logic fire;
    logic in_take;

    always_comb begin
        advance     = !r_out_valid || !i_out_stall;
        fire        = r_in_valid && advance;
        o_in_stall  = r_in_valid && !advance;
        in_take     = i_in_valid && !o_in_stall;
        n_in_valid  = in_take || (r_in_valid && !fire);
        n_out_valid = fire || (r_out_valid && i_out_stall);
    end

    aht_table u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_word   (r_in_word),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_word <= i_in_word;
        end
        if (fire) begin
            r_out_word <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// ===== design/aht_checker.sv =====
// Port-level checks of the hazard tracker, bound to the top level.
// Depends on aht_pkg and access_hazard_tracker_core_macros.svh.
`include "access_hazard_tracker_core_macros.svh"

module aht_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input aht_pkg::t_out_word o_out_word
);

    // a held word must not change under stall
    `AHT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_word))

    // a full table reports overflow without a barrier
    `AHT_ASSERT_NOW(a_ovf_no_barrier, i_clk, i_rst_n, o_out_valid && o_out_word.table_overflow, !o_out_word.barrier_needed)

    // no barrier: all barrier detail is zero
    `AHT_ASSERT_NOW(a_idle_fields_zero, i_clk, i_rst_n, o_out_valid && !o_out_word.barrier_needed, (o_out_word.barrier_key == '0) && !o_out_word.src_read && !o_out_word.src_write && !o_out_word.dst_read && !o_out_word.dst_write)

    // a barrier is only raised around a write, and the new access has a flag
    `AHT_ASSERT_NOW(a_barrier_write, i_clk, i_rst_n, o_out_valid && o_out_word.barrier_needed, (o_out_word.src_write || o_out_word.dst_write) && (o_out_word.dst_read || o_out_word.dst_write))

endmodule

bind access_hazard_tracker_core aht_checker u_aht_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);
